// ===== rtl/owc_pkg.sv =====
package owc_pkg;

  localparam logic [7:0] SYS_DRIVETRAIN = 8'd100;
  localparam logic [7:0] CMD_POSE       = 8'd36;
  localparam logic [7:0] CMD_VELOCITY   = 8'd37;
  localparam logic [3:0] LEN_POSE       = 4'd6;
  localparam logic [3:0] LEN_VELOCITY   = 4'd4;
  localparam int         NUM_RESULTS    = 14;
  localparam int         NUM_VALUES     = 5;
  localparam int         NUM_PAIRS      = 9;
  localparam logic [4:0] WINDOW_RESET   = 5'd10;
  // result selects: first covariance, and the marker for loading the current slot
  localparam logic [3:0] COV_FIRST      = 4'd5;
  localparam logic [3:0] SEL_CUR        = 4'd15;
  // scale factor and its square
  localparam logic signed [10:0] SCALE    = 11'sd1000;
  localparam logic [19:0]        SCALE_SQ = 20'd1000000;

  // wide enough for n*sum(ab) - sum(a)*sum(b) at window 256
  localparam int ACC_W  = 48;
  localparam int DIFF_W = 58;
  localparam int QUO_W  = 17;

  // controller to datapath commands
  typedef struct packed {
    logic       store_pose;
    logic       store_twist;
    logic       clr_acc;
    logic       rd_en;
    logic       acc_en;
    logic       ld_pair;
    logic       mul_step;
    logic       div_start;
    logic       out_load;
    logic [3:0] result_sel;
  } owc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
  } owc_sts_t;

  // first element of each covariance pair
  function automatic logic [2:0] pair_a(input logic [3:0] k);
    logic [2:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 3'd0;
      4'd3, 4'd4:       r = 3'd1;
      4'd5:             r = 3'd2;
      4'd6, 4'd7:       r = 3'd3;
      default:          r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_b(input logic [3:0] k);
    logic [2:0] r;
    case (k)
      4'd0:             r = 3'd0;
      4'd1, 4'd3:       r = 3'd1;
      4'd2, 4'd4, 4'd5: r = 3'd2;
      4'd6:             r = 3'd3;
      default:          r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/owc_datapath.sv =====
module owc_datapath #(
  parameter int WINDOW_MAX = 16,
  parameter int IDX_W      = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  owc_pkg::owc_cmd_t          cmd,
  output owc_pkg::owc_sts_t          sts,
  input  logic [IDX_W-1:0]           slot,
  input  logic [IDX_W-1:0]           rd_idx,
  input  logic [IDX_W:0]             count,
  input  logic [63:0]                payload,
  input  logic [31:0]                seq,
  output logic [3:0]                 out_result_index,
  output logic signed [62:0]         out_result_value,
  output logic [31:0]                out_sequence_number,
  output logic                       out_last_of_run
);
  import owc_pkg::*;

  // history memories, registered read
  logic [47:0] pose_mem [WINDOW_MAX];
  logic [31:0] twist_mem [WINDOW_MAX];
  logic [47:0] pose_rd_r;
  logic [31:0] twist_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.store_pose) begin
      pose_mem[slot]  <= payload[63:16];
      twist_mem[slot] <= 32'd0;
    end else if (cmd.store_twist) begin
      twist_mem[slot] <= payload[63:32];
    end
    if (cmd.rd_en) begin
      pose_rd_r  <= pose_mem[rd_idx];
      twist_rd_r <= twist_mem[rd_idx];
    end
  end

  // sample vector from the read port
  logic signed [15:0] s [NUM_VALUES];
  assign s[0] = pose_rd_r[47:32];
  assign s[1] = pose_rd_r[31:16];
  assign s[2] = pose_rd_r[15:0];
  assign s[3] = twist_rd_r[31:16];
  assign s[4] = twist_rd_r[15:0];

  // window accumulators
  logic signed [ACC_W-1:0] sum_r  [NUM_VALUES];
  logic signed [ACC_W-1:0] prod_r [NUM_PAIRS];
  logic signed [15:0]      cur_r  [NUM_VALUES];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_VALUES; a++) begin
      if (cmd.clr_acc) begin
        sum_r[a] <= '0;
      end else if (cmd.acc_en) begin
        sum_r[a] <= sum_r[a] + ACC_W'(s[a]);
      end
    end
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (cmd.clr_acc) begin
        prod_r[k] <= '0;
      end else if (cmd.acc_en) begin
        prod_r[k] <= prod_r[k] + ACC_W'(s[pair_a(4'(k))] * s[pair_b(4'(k))]);
      end
    end
    // latch current slot values (first read is the slot)
    if (cmd.ld_pair && cmd.result_sel == SEL_CUR) begin
      for (int a = 0; a < NUM_VALUES; a++) cur_r[a] <= s[a];
    end
  end

  // covariance numerator, built in a few multiply steps
  logic [1:0]               mstep_r;
  logic signed [DIFF_W-1:0] d_r;
  logic signed [31:0]       sa_r, sb_r;
  logic signed [ACC_W-1:0]  sab_r;
  logic signed [63:0]       sasb;
  logic [3:0]               kk;
  assign kk   = cmd.result_sel - COV_FIRST;
  // window sums stay far below 32 bits
  assign sasb = sa_r * sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= '0;
    end else if (cmd.ld_pair && cmd.result_sel != SEL_CUR) begin
      sa_r    <= 32'(sum_r[pair_a(kk)]);
      sb_r    <= 32'(sum_r[pair_b(kk)]);
      sab_r   <= prod_r[kk];
      mstep_r <= 2'd1;
    end else if (cmd.mul_step && mstep_r == 2'd1) begin
      d_r     <= DIFF_W'(sab_r * $signed({1'b0, count}));
      mstep_r <= 2'd2;
    end else if (cmd.mul_step && mstep_r == 2'd2) begin
      d_r     <= d_r - DIFF_W'(sasb);
      mstep_r <= 2'd3;
    end
  end
  assign sts.mul_done = (mstep_r == 2'd3);

  // serial restoring divider: m*1e6 / (n*(n-1))
  localparam int NUM_W = DIFF_W + 20;
  logic [NUM_W-1:0] dq_r;
  logic [QUO_W-1:0] dv_r;
  logic [QUO_W:0]   rem_r;
  logic [6:0]       dcnt_r;
  logic             dbusy_r, dneg_r;
  logic [QUO_W:0]   rtry;
  logic [DIFF_W-1:0] dmag;
  assign dmag = d_r[DIFF_W-1] ? DIFF_W'(-d_r) : DIFF_W'(d_r);
  assign rtry = {rem_r[QUO_W-1:0], dq_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dq_r    <= NUM_W'(dmag) * NUM_W'(SCALE_SQ);
      dv_r    <= QUO_W'(count) * QUO_W'(count - 1'b1);
      dneg_r  <= d_r[DIFF_W-1];
      rem_r   <= '0;
      dcnt_r  <= 7'(NUM_W);
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      if (rtry >= {1'b0, dv_r}) begin
        rem_r <= rtry - {1'b0, dv_r};
        dq_r  <= {dq_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rtry;
        dq_r  <= {dq_r[NUM_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 7'd1;
      if (dcnt_r == 7'd1) dbusy_r <= 1'b0;
    end
  end
  assign sts.div_done = !dbusy_r && !cmd.div_start;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_index    <= cmd.result_sel;
      out_sequence_number <= seq;
      out_last_of_run     <= (cmd.result_sel == 4'(NUM_RESULTS - 1));
      if (cmd.result_sel < COV_FIRST) begin
        out_result_value <= 63'(cur_r[cmd.result_sel[2:0]] * SCALE);
      end else begin
        out_result_value <= dneg_r ? -63'(dq_r) : 63'(dq_r);
      end
    end
  end

endmodule

// ===== rtl/owc_ctrl.sv =====
module owc_ctrl #(
  parameter int WINDOW_MAX = 16,
  parameter int IDX_W      = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        system_id,
  input  logic [7:0]        command_id,
  input  logic [3:0]        frame_length,
  input  logic [4:0]        cfg_window,
  output logic              out_valid,
  input  logic              out_ready,
  output owc_pkg::owc_cmd_t cmd,
  input  owc_pkg::owc_sts_t sts,
  output logic [IDX_W-1:0]  slot,
  output logic [IDX_W-1:0]  rd_idx,
  output logic [IDX_W:0]    count,
  output logic [31:0]       seq
);
  import owc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_CUR   = 8'b00000100,
    S_PAIR  = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_MOD   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W:0]   cnt_r, cnt_nxt, win_r, win_nxt;
  logic [IDX_W:0]   ri_r, ri_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [31:0]      oseq_r, oseq_nxt;
  logic             ov_r, ov_nxt;
  logic [4:0]       mb_r, mb_nxt;

  // effective window
  logic [IDX_W:0] weff;
  always_comb begin
    if (cfg_window < 5'd2) weff = (IDX_W+1)'(2);
    else if (32'(cfg_window) > WINDOW_MAX) weff = (IDX_W+1)'(WINDOW_MAX);
    else weff = (IDX_W+1)'(cfg_window);
  end

  logic acc, hit, is_pose, is_vel;
  assign in_ready  = (state_r == S_IDLE) && (weff == win_r);
  assign acc       = in_valid && in_ready;
  assign hit       = system_id == SYS_DRIVETRAIN;
  assign is_pose   = hit && command_id == CMD_POSE && frame_length >= LEN_POSE;
  assign is_vel    = hit && command_id == CMD_VELOCITY && frame_length >= LEN_VELOCITY;
  assign out_valid = ov_r;
  assign slot      = slot_r;
  assign count     = cnt_r;
  assign seq       = oseq_r;
  assign rd_idx    = ri_r[IDX_W-1:0];

  logic [31:0] seq_inc;
  assign seq_inc = seq_r + 32'd1;

  // next slot, wrapping at the window
  logic [IDX_W:0]   slot_inc;
  logic [IDX_W-1:0] slot_adv;
  assign slot_inc = {1'b0, slot_r} + 1'b1;
  assign slot_adv = (slot_inc == win_r) ? '0 : slot_inc[IDX_W-1:0];

  // remainder step for the slot recompute
  logic [IDX_W:0] mod_try;
  assign mod_try = {slot_r, seq_r[mb_r]};

  always_comb begin
    state_nxt = state_r;
    seq_nxt = seq_r; slot_nxt = slot_r; cnt_nxt = cnt_r; win_nxt = win_r;
    ri_nxt = ri_r; k_nxt = k_r; oseq_nxt = oseq_r; ov_nxt = ov_r; mb_nxt = mb_r;
    cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (weff != win_r) begin
          // window changed: rebuild the slot as seq mod window
          win_nxt = weff;
          slot_nxt = '0;
          mb_nxt = 5'd31;
          state_nxt = S_MOD;
        end else if (acc && is_pose) begin
          cmd.store_pose = 1'b1;
          cmd.store_twist = 1'b0;
        end else if (acc && is_vel) begin
          cmd.store_twist = 1'b1;
          seq_nxt = seq_inc;
          oseq_nxt = seq_r;
          if (seq_inc < 32'(win_r)) cnt_nxt = (IDX_W+1)'(seq_inc);
          else cnt_nxt = win_r;
          if (seq_inc >= 32'd2) begin
            cmd.clr_acc = 1'b1;
            ri_nxt = '0;
            state_nxt = S_READ;
          end else begin
            slot_nxt = (seq_inc == '0) ? '0 : slot_adv;
          end
        end
      end
      // one remainder bit a cycle, msb first
      S_MOD: begin
        slot_nxt = (mod_try >= win_r) ? IDX_W'(mod_try - win_r) : IDX_W'(mod_try);
        mb_nxt = mb_r - 5'd1;
        if (mb_r == '0) state_nxt = S_IDLE;
      end
      // walk the window, one entry a cycle
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (ri_r != '0) cmd.acc_en = 1'b1;
        if (ri_r == cnt_r) begin
          cmd.rd_en = 1'b0;
          ri_nxt = {1'b0, slot_r};
          state_nxt = S_CUR;
        end else begin
          ri_nxt = ri_r + 1'b1;
        end
      end
      S_CUR: begin
        cmd.rd_en = 1'b1;
        if (ri_r[IDX_W] == 1'b1) begin
          cmd.ld_pair = 1'b1;
          cmd.result_sel = SEL_CUR;
          k_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          ri_nxt = {1'b1, ri_r[IDX_W-1:0]};
        end
      end
      S_PAIR: begin
        cmd.ld_pair = 1'b1;
        cmd.result_sel = k_r;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.result_sel = k_r;
        if (sts.mul_done) begin
          cmd.mul_step = 1'b0;
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.result_sel = k_r;
          ov_nxt = 1'b1;
          if (k_r == 4'(NUM_RESULTS - 1)) begin
            slot_nxt = slot_adv;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 4'd1;
            state_nxt = (k_r >= COV_FIRST - 4'd1) ? S_PAIR : S_OUT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_r   <= '0;
      ov_r    <= 1'b0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      ov_r    <= ov_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt; cnt_r <= cnt_nxt; mb_r <= mb_nxt;
    ri_r <= ri_nxt; k_r <= k_nxt; oseq_r <= oseq_nxt;
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_vel) |=> seq_r == $past(seq_r) + 32'd1) else $error("seq step");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> cnt_r >= (IDX_W+1)'(2)) else $error("count");
endmodule

// ===== rtl/odometry_window_covariance.sv =====
// channel | direction | handshake
// in_     | input     | in_valid / in_ready
// out_    | output    | out_valid / out_ready
// cfg_    | input     | cfg_write_enable, no wait
// A velocity frame with two or more samples walks the window, then computes
// each covariance by a load, the multiply steps, the serial divider and the
// output load. Other frames are handled without leaving idle. A window change
// holds off input while the slot is recomputed.
// Reset is synchronous, active low; history memories are not cleared.
// out_ stalls hold the run; input waits until the last result is loaded.
module odometry_window_covariance #(
  parameter int WINDOW_MAX = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_system_id,
  input  logic [7:0]         in_command_id,
  input  logic [3:0]         in_frame_length,
  input  logic [63:0]        in_payload,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_result_index,
  output logic signed [62:0] out_result_value,
  output logic [31:0]        out_sequence_number,
  output logic               out_last_of_run,
  input  logic               cfg_write_enable,
  input  logic [4:0]         cfg_window_size
);
  import owc_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_MAX);

  logic [4:0] win_r;
  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= WINDOW_RESET;
    else if (cfg_write_enable) win_r <= cfg_window_size;
  end

  owc_cmd_t cmd;
  owc_sts_t sts;
  logic [IDX_W-1:0] slot, rd_idx;
  logic [IDX_W:0]   count;
  logic [31:0]      seq;

  owc_ctrl #(.WINDOW_MAX(WINDOW_MAX), .IDX_W(IDX_W)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .system_id(in_system_id), .command_id(in_command_id),
    .frame_length(in_frame_length), .cfg_window(win_r),
    .out_valid, .out_ready, .cmd, .sts, .slot, .rd_idx, .count, .seq
  );

  owc_datapath #(.WINDOW_MAX(WINDOW_MAX), .IDX_W(IDX_W)) u_dp (
    .clk, .rst_n, .cmd, .sts, .slot, .rd_idx, .count,
    .payload(in_payload), .seq,
    .out_result_index, .out_result_value, .out_sequence_number, .out_last_of_run
  );
endmodule
